// ===== design/rtpf_pkg.sv =====
// Package for the resistive touch point filter: widths, register codes,
// the payload struct carried through the divider and the axis selection function.
// Depends on nothing.
package rtpf_pkg;

   localparam int SAMPLE_BITS = 10;
   localparam int PLATE_BITS  = 16;
   localparam int TOL_BITS    = 10;
   localparam int FRAC_BITS   = 4;
   localparam int PRESS_BITS  = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;
   localparam logic [TOL_BITS-1:0]    TOL_RESET  = TOL_BITS'(4);

   // (z2 - z1) * x * plate * 16 / (z1 * 2^SAMPLE_BITS) equals
   // floor(num >> (SAMPLE_BITS - FRAC_BITS)) / z1.
   localparam int PROD_BITS  = 2 * SAMPLE_BITS;
   localparam int NUM_BITS   = PROD_BITS + PLATE_BITS;
   localparam int NUM_SHIFT  = SAMPLE_BITS - FRAC_BITS;
   localparam int QUO_BITS   = NUM_BITS - NUM_SHIFT;
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int DIV_STAGES = (QUO_BITS + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
   localparam int DIV_WIDTH  = DIV_STAGES * DIV_BITS_PER_STAGE;

   typedef enum logic {
      CSR_PLATE     = 1'b0,
      CSR_TOLERANCE = 1'b1
   } csr_index_type;

   // Everything that rides alongside the quotient through the divider.
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] x_position;
      logic [SAMPLE_BITS-1:0] y_position;
      logic                   ok;
      logic                   neg;
      logic                   raw_mode;
      logic [PRESS_BITS-1:0]  raw_press;
   } rtpf_side_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   ok;
   } axis_pick_type;

   // Average of the two samples when they agree, else the second one.
   function automatic axis_pick_type pick_axis(input logic [SAMPLE_BITS-1:0] a,
                                               input logic [SAMPLE_BITS-1:0] b,
                                               input logic [TOL_BITS-1:0] tol);
      axis_pick_type          r;
      logic [SAMPLE_BITS-1:0] d;
      logic [SAMPLE_BITS:0]   sum;
      d   = (a > b) ? (a - b) : (b - a);
      sum = {1'b0, a} + {1'b0, b};
      if (d > SAMPLE_BITS'(tol)) begin
         r.sample = b;
         r.ok     = 1'b0;
      end else begin
         r.sample = sum[SAMPLE_BITS:1];
         r.ok     = 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== design/rtpf_div.sv =====
// Pipelined restoring divider for the pressure quotient, two quotient bits per stage.
// Depends on rtpf_pkg for widths and the side payload struct.
module rtpf_div import rtpf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [DIV_WIDTH-1:0]   in_dividend,
   input  logic [SAMPLE_BITS-1:0] in_divisor,
   input  rtpf_side_type          in_side,
   output logic                   out_valid,
   output logic [DIV_WIDTH-1:0]   out_quotient,
   output rtpf_side_type          out_side
);

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] rem;
      logic [DIV_WIDTH-1:0]   num;
      logic [DIV_WIDTH-1:0]   quo;
   } div_state_type;

   function automatic div_state_type div_step(input div_state_type s,
                                              input logic [SAMPLE_BITS-1:0] den);
      div_state_type        r;
      logic [SAMPLE_BITS:0] trial;
      r = s;
      for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
         trial = {r.rem, r.num[DIV_WIDTH-1]};
         r.num = {r.num[DIV_WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, den}) begin
            r.rem = SAMPLE_BITS'(trial - {1'b0, den});
            r.quo = {r.quo[DIV_WIDTH-2:0], 1'b1};
         end else begin
            r.rem = trial[SAMPLE_BITS-1:0];
            r.quo = {r.quo[DIV_WIDTH-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   logic                   valid_ff [DIV_STAGES];
   div_state_type          state_ff [DIV_STAGES];
   logic [SAMPLE_BITS-1:0] den_ff   [DIV_STAGES];
   rtpf_side_type          side_ff  [DIV_STAGES];

   logic                   prev_valid [DIV_STAGES];
   div_state_type          prev_state [DIV_STAGES];
   logic [SAMPLE_BITS-1:0] prev_den   [DIV_STAGES];
   rtpf_side_type          prev_side  [DIV_STAGES];
   div_state_type          state_in   [DIV_STAGES];

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
      if (g == 0) begin : g_first
         always_comb begin
            prev_valid[g]     = in_valid;
            prev_state[g].rem = '0;
            prev_state[g].num = in_dividend;
            prev_state[g].quo = '0;
            prev_den[g]       = in_divisor;
            prev_side[g]      = in_side;
         end
      end else begin : g_rest
         always_comb begin
            prev_valid[g] = valid_ff[g-1];
            prev_state[g] = state_ff[g-1];
            prev_den[g]   = den_ff[g-1];
            prev_side[g]  = side_ff[g-1];
         end
      end

      always_comb state_in[g] = div_step(prev_state[g], prev_den[g]);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= prev_valid[g];
         end
      end

      always_ff @(posedge clock) begin
         state_ff[g] <= state_in[g];
         den_ff[g]   <= prev_den[g];
         side_ff[g]  <= prev_side[g];
      end
   end

   assign out_valid    = valid_ff[DIV_STAGES-1];
   assign out_quotient = state_ff[DIV_STAGES-1].quo;
   assign out_side     = side_ff[DIV_STAGES-1];

endmodule

// ===== design/resistive_touch_point_filter.sv =====
// Top level of the resistive touch point filter: register file, front pipeline
// stages, divider and result register. Depends on rtpf_pkg and rtpf_div.
//
// The block takes one complete four-wire reading per clock cycle (start high)
// and never raises busy, so a new word can follow in every cycle. Each word
// leaves on the rsp_ ports from the result register, marked by a
// one-cycle rsp_strobe; the receiver cannot hold results off, so it must take
// each word in the cycle the strobe is high. The pipeline holds, in order:
// one stage for axis selection and the Z difference, two stages for the
// difference times position times plate resistance product, 15 stages of the
// divider that resolves two quotient bits each, and the result register.
// Configuration writes through the APB port are meant to happen while no
// reading is in flight; plate_resistance sits at byte address 0 and
// noise_tolerance at byte address 4.
module resistive_touch_point_filter import rtpf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // Input words
   input  logic                     start,
   output logic                     busy,
   input  logic [SAMPLE_BITS-1:0]   req_x_sample_first,
   input  logic [SAMPLE_BITS-1:0]   req_x_sample_second,
   input  logic [SAMPLE_BITS-1:0]   req_y_sample_first,
   input  logic [SAMPLE_BITS-1:0]   req_y_sample_second,
   input  logic [SAMPLE_BITS-1:0]   req_z_first_sample,
   input  logic [SAMPLE_BITS-1:0]   req_z_second_sample,
   // Result words
   output logic                     rsp_strobe,
   output logic [SAMPLE_BITS-1:0]   rsp_x_position,
   output logic [SAMPLE_BITS-1:0]   rsp_y_position,
   output logic signed [PRESS_BITS-1:0] rsp_touch_pressure,
   output logic                     rsp_point_valid,
   // Configuration port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   // ---------------------------------------------------------------- registers
   logic [PLATE_BITS-1:0] plate_ff;
   logic [TOL_BITS-1:0]   tol_ff;
   csr_index_type         csr_index;
   logic                  csr_write;

   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[2]);
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         plate_ff <= '0;
         tol_ff   <= TOL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PLATE:     plate_ff <= pwdata[PLATE_BITS-1:0];
            CSR_TOLERANCE: tol_ff   <= pwdata[TOL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_PLATE:     prdata = CSR_DATA_BITS'(plate_ff);
         CSR_TOLERANCE: prdata = CSR_DATA_BITS'(tol_ff);
         default:       prdata = '0;
      endcase
   end

   // The pipeline never stalls, so a word is taken whenever start is high.
   assign busy = 1'b0;

   // ---------------------------------------------------------------- stage 1
   // Pick each axis, invert it, and form |z2 - z1| with its sign. The raw
   // pressure (full scale minus the signed Z difference) is finished here too.
   axis_pick_type          x_pick, y_pick;
   logic [SAMPLE_BITS-1:0] z_diff;
   logic                   z_neg;
   logic [SAMPLE_BITS:0]   raw_sum;
   rtpf_side_type          s1_side_in;

   always_comb begin
      x_pick  = pick_axis(req_x_sample_first, req_x_sample_second, tol_ff);
      y_pick  = pick_axis(req_y_sample_first, req_y_sample_second, tol_ff);
      z_neg   = req_z_second_sample < req_z_first_sample;
      z_diff  = z_neg ? (req_z_first_sample - req_z_second_sample)
                      : (req_z_second_sample - req_z_first_sample);
      raw_sum = z_neg ? ({1'b0, FULL_SCALE} + {1'b0, z_diff})
                      : ({1'b0, FULL_SCALE} - {1'b0, z_diff});
      s1_side_in.x_position = FULL_SCALE - x_pick.sample;
      s1_side_in.y_position = FULL_SCALE - y_pick.sample;
      s1_side_in.ok         = x_pick.ok & y_pick.ok & (req_z_first_sample != '0);
      s1_side_in.neg        = z_neg;
      s1_side_in.raw_mode   = (plate_ff == '0);
      s1_side_in.raw_press  = PRESS_BITS'({raw_sum, {FRAC_BITS{1'b0}}});
   end

   logic                   s1_valid_ff;
   rtpf_side_type          s1_side_ff;
   logic [SAMPLE_BITS-1:0] s1_z1_ff;
   logic [SAMPLE_BITS-1:0] s1_diff_ff;
   logic [PLATE_BITS-1:0]  s1_plate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      s1_side_ff  <= s1_side_in;
      s1_z1_ff    <= req_z_first_sample;
      s1_diff_ff  <= z_diff;
      s1_plate_ff <= plate_ff;
   end

   // ---------------------------------------------------------------- stage 2
   // Z difference times the X position.
   logic [PROD_BITS-1:0] s2_prod_in;
   assign s2_prod_in = PROD_BITS'(s1_diff_ff) * PROD_BITS'(s1_side_ff.x_position);

   logic                   s2_valid_ff;
   rtpf_side_type          s2_side_ff;
   logic [SAMPLE_BITS-1:0] s2_z1_ff;
   logic [PROD_BITS-1:0]   s2_prod_ff;
   logic [PLATE_BITS-1:0]  s2_plate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_side_ff  <= s1_side_ff;
      s2_z1_ff    <= s1_z1_ff;
      s2_prod_ff  <= s2_prod_in;
      s2_plate_ff <= s1_plate_ff;
   end

   // ---------------------------------------------------------------- stage 3
   // Times the plate resistance. Dividing by z1 * 2^SAMPLE_BITS after the
   // fraction shift is the same as dropping the low bits here and dividing by z1.
   logic [NUM_BITS-1:0]  s3_full;
   logic [DIV_WIDTH-1:0] s3_num_in;

   assign s3_full   = NUM_BITS'(s2_prod_ff) * NUM_BITS'(s2_plate_ff);
   assign s3_num_in = DIV_WIDTH'(s3_full >> NUM_SHIFT);

   logic                   s3_valid_ff;
   rtpf_side_type          s3_side_ff;
   logic [SAMPLE_BITS-1:0] s3_z1_ff;
   logic [DIV_WIDTH-1:0]   s3_num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_side_ff <= s2_side_ff;
      s3_z1_ff   <= s2_z1_ff;
      s3_num_ff  <= s3_num_in;
   end

   // ---------------------------------------------------------------- divider
   // A zero z1 yields a meaningless quotient, but such a point is invalid and
   // its pressure is forced to zero below.
   logic                 div_valid;
   logic [DIV_WIDTH-1:0] div_quotient;
   rtpf_side_type        div_side;

   rtpf_div u_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s3_valid_ff),
      .in_dividend  (s3_num_ff),
      .in_divisor   (s3_z1_ff),
      .in_side      (s3_side_ff),
      .out_valid    (div_valid),
      .out_quotient (div_quotient),
      .out_side     (div_side)
   );

   // ---------------------------------------------------------------- result
   // The quotient stays below 2^31 for in-range samples, so it never needs
   // saturation; a negative Z difference simply negates it.
   logic [PRESS_BITS-1:0] mag;
   logic [PRESS_BITS-1:0] press_in;

   always_comb begin
      mag = PRESS_BITS'(div_quotient);
      if (!div_side.ok) begin
         press_in = '0;
      end else if (div_side.raw_mode) begin
         press_in = div_side.raw_press;
      end else if (div_side.neg) begin
         press_in = PRESS_BITS'(0) - mag;
      end else begin
         press_in = mag;
      end
   end

   logic                   out_valid_ff;
   logic [SAMPLE_BITS-1:0] out_x_ff;
   logic [SAMPLE_BITS-1:0] out_y_ff;
   logic [PRESS_BITS-1:0]  out_press_ff;
   logic                   out_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      out_x_ff     <= div_side.x_position;
      out_y_ff     <= div_side.y_position;
      out_press_ff <= press_in;
      out_ok_ff    <= div_side.ok;
   end

   assign rsp_strobe         = out_valid_ff;
   assign rsp_x_position     = out_x_ff;
   assign rsp_y_position     = out_y_ff;
   assign rsp_touch_pressure = signed'(out_press_ff);
   assign rsp_point_valid    = out_ok_ff;

endmodule

// ===== dv/touch_point_checker.sv =====
`timescale 1ns / 100ps
// Checker for the resistive touch point filter: watches the reading, result and
// APB channels, predicts each result word and compares it. Depends on rtpf_pkg.
module touch_point_checker import rtpf_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [SAMPLE_BITS-1:0]       req_x_sample_first,
   input  logic [SAMPLE_BITS-1:0]       req_x_sample_second,
   input  logic [SAMPLE_BITS-1:0]       req_y_sample_first,
   input  logic [SAMPLE_BITS-1:0]       req_y_sample_second,
   input  logic [SAMPLE_BITS-1:0]       req_z_first_sample,
   input  logic [SAMPLE_BITS-1:0]       req_z_second_sample,
   input  logic                         rsp_strobe,
   input  logic [SAMPLE_BITS-1:0]       rsp_x_position,
   input  logic [SAMPLE_BITS-1:0]       rsp_y_position,
   input  logic signed [PRESS_BITS-1:0] rsp_touch_pressure,
   input  logic                         rsp_point_valid,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [CSR_ADDR_BITS-1:0]     paddr,
   input  logic [CSR_DATA_BITS-1:0]     pwdata,
   input  logic [CSR_DATA_BITS-1:0]     prdata,
   input  logic                         pready,
   output int                           failures,
   output int                           outstanding
);

   typedef struct packed {
      logic [SAMPLE_BITS-1:0]       x_position;
      logic [SAMPLE_BITS-1:0]       y_position;
      logic signed [PRESS_BITS-1:0] touch_pressure;
      logic                         point_valid;
   } touch_point_type;

   touch_point_type        expected_points[$];
   logic [PLATE_BITS-1:0]  plate_ohms = '0;
   logic [TOL_BITS-1:0]    tolerance  = TOL_RESET;
   int                     errors     = 0;

   // Average of the pair when it agrees within the tolerance, else the second sample.
   function automatic logic [SAMPLE_BITS-1:0] settle_axis(input logic [SAMPLE_BITS-1:0] a,
                                                          input logic [SAMPLE_BITS-1:0] b,
                                                          output logic agree);
      logic [SAMPLE_BITS-1:0] spread;
      spread = (a > b) ? a - b : b - a;
      agree  = (spread <= tolerance);
      return agree ? SAMPLE_BITS'(((SAMPLE_BITS+1)'(a) + (SAMPLE_BITS+1)'(b)) >> 1) : b;
   endfunction

   function automatic touch_point_type evaluate_touch(input logic [SAMPLE_BITS-1:0] x1, x2,
                                                      input logic [SAMPLE_BITS-1:0] y1, y2,
                                                      input logic [SAMPLE_BITS-1:0] z1, z2);
      touch_point_type        r;
      logic                   x_ok, y_ok, ok, neg;
      logic [SAMPLE_BITS-1:0] xs, ys, dz;
      logic [63:0]            mag;
      xs = settle_axis(x1, x2, x_ok);
      ys = settle_axis(y1, y2, y_ok);
      r.x_position     = FULL_SCALE - xs;
      r.y_position     = FULL_SCALE - ys;
      ok               = x_ok && y_ok && (z1 != '0);
      r.touch_pressure = '0;
      if (ok) begin
         neg = z2 < z1;
         dz  = neg ? z1 - z2 : z2 - z1;
         if (plate_ohms != '0) begin
            mag = ((64'(dz) * 64'(r.x_position) * 64'(plate_ohms)) << FRAC_BITS)
                  / (64'(z1) << SAMPLE_BITS);
            if (neg && mag != 64'd0)
               r.touch_pressure = (mag >= 64'h8000_0000) ? 32'h8000_0000
                                                         : PRESS_BITS'(64'd0 - mag);
            else
               r.touch_pressure = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
         end else begin
            // Raw mode reports full scale minus (z2 - z1), which cannot go negative.
            mag = neg ? 64'(FULL_SCALE) + 64'(dz) : 64'(FULL_SCALE) - 64'(dz);
            r.touch_pressure = PRESS_BITS'(mag << FRAC_BITS);
         end
      end
      r.point_valid = ok;
      return r;
   endfunction

   always @(posedge clock) begin
      touch_point_type          seen, want;
      logic [CSR_DATA_BITS-1:0] reg_value;
      if (reset) begin
         expected_points.delete();
         plate_ohms = '0;
         tolerance  = TOL_RESET;
      end else begin
         if (psel && penable && pready && paddr[1:0] == 2'b00) begin
            case (csr_index_type'(paddr[CSR_ADDR_BITS-1]))
               CSR_PLATE:     reg_value = CSR_DATA_BITS'(plate_ohms);
               CSR_TOLERANCE: reg_value = CSR_DATA_BITS'(tolerance);
               default:       reg_value = '0;
            endcase
            if (pwrite) begin
               case (csr_index_type'(paddr[CSR_ADDR_BITS-1]))
                  CSR_PLATE:     plate_ohms = pwdata[PLATE_BITS-1:0];
                  CSR_TOLERANCE: tolerance  = pwdata[TOL_BITS-1:0];
                  default: ;
               endcase
            end else if (prdata !== reg_value) begin
               errors++;
               if (errors <= 10)
                  $display("%0t register read at %0d: expected %h, got %h",
                           $realtime, paddr, reg_value, prdata);
            end
         end
         if (rsp_strobe) begin
            seen = '{rsp_x_position, rsp_y_position, rsp_touch_pressure, rsp_point_valid};
            if (expected_points.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t result word with nothing expected: x %0d y %0d p %0d v %0d",
                           $realtime, seen.x_position, seen.y_position,
                           seen.touch_pressure, seen.point_valid);
            end else begin
               want = expected_points.pop_front();
               if (seen.x_position !== want.x_position || seen.y_position !== want.y_position
                   || seen.touch_pressure !== want.touch_pressure
                   || seen.point_valid !== want.point_valid) begin
                  errors++;
                  if (errors <= 10)
                     $display({"%0t result mismatch: expected x %0d y %0d p %0d v %0d,",
                               " got x %0d y %0d p %0d v %0d"}, $realtime,
                              want.x_position, want.y_position, want.touch_pressure,
                              want.point_valid, seen.x_position, seen.y_position,
                              seen.touch_pressure, seen.point_valid);
               end
            end
         end
         if (start && !busy)
            expected_points.push_back(evaluate_touch(req_x_sample_first, req_x_sample_second,
                                                     req_y_sample_first, req_y_sample_second,
                                                     req_z_first_sample, req_z_second_sample));
      end
      outstanding <= expected_points.size();
      failures    <= errors;
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the resistive touch point filter testbench: clock, reset, APB register
// programming and reading stimulus. Depends on rtpf_pkg, the block and touch_point_checker.
module testbench;
   import rtpf_pkg::*;

   // Depth of the block's pipeline, from a taken word to its result word.
   localparam int LATENCY      = 19;
   localparam int LIMIT_CYCLES = 200000;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [SAMPLE_BITS-1:0]       req_x_sample_first;
   logic [SAMPLE_BITS-1:0]       req_x_sample_second;
   logic [SAMPLE_BITS-1:0]       req_y_sample_first;
   logic [SAMPLE_BITS-1:0]       req_y_sample_second;
   logic [SAMPLE_BITS-1:0]       req_z_first_sample;
   logic [SAMPLE_BITS-1:0]       req_z_second_sample;
   logic                         rsp_strobe;
   logic [SAMPLE_BITS-1:0]       rsp_x_position;
   logic [SAMPLE_BITS-1:0]       rsp_y_position;
   logic signed [PRESS_BITS-1:0] rsp_touch_pressure;
   logic                         rsp_point_valid;
   logic                         psel;
   logic                         penable;
   logic                         pwrite;
   logic [CSR_ADDR_BITS-1:0]     paddr;
   logic [CSR_DATA_BITS-1:0]     pwdata;
   logic [CSR_DATA_BITS-1:0]     prdata;
   logic                         pready;
   int                           failures;
   int                           outstanding;
   int                           cycle_count;

   resistive_touch_point_filter dut (
      .clock, .reset, .start, .busy,
      .req_x_sample_first, .req_x_sample_second,
      .req_y_sample_first, .req_y_sample_second,
      .req_z_first_sample, .req_z_second_sample,
      .rsp_strobe, .rsp_x_position, .rsp_y_position,
      .rsp_touch_pressure, .rsp_point_valid,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   // The checker sees the same wires as the block and reports its failure count
   // and the number of result words still owed.
   touch_point_checker point_check (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: LIMIT_CYCLES lies far above the slowest legal run, so reaching this
   // limit means the block has stopped answering.
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // One APB transfer. psel stays high afterwards so that a following transfer
   // can start with its setup cycle at once; the caller drops it when done.
   task automatic csr_access(input logic write_access, input csr_index_type index,
                             input logic [CSR_DATA_BITS-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write_access;
      paddr   <= CSR_ADDR_BITS'({index, 2'b00});
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   // Writes both registers with random junk in the unused upper bits, which the
   // block must drop, and reads them back so that the checker sees the stored value.
   task automatic program_registers(input int plate, input int tol);
      logic [CSR_DATA_BITS-1:0] data;
      data = $urandom;
      data[PLATE_BITS-1:0] = PLATE_BITS'(plate);
      csr_access(1'b1, CSR_PLATE, data);
      data = $urandom;
      data[TOL_BITS-1:0] = TOL_BITS'(tol);
      csr_access(1'b1, CSR_TOLERANCE, data);
      csr_access(1'b0, CSR_PLATE, '0);
      csr_access(1'b0, CSR_TOLERANCE, '0);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Offers one reading and returns at the edge that takes it. Before the word
   // the sender may sit idle; each cycle is idle with the given percentage.
   task automatic drive_word(input int x1, input int x2, input int y1, input int y2,
                             input int z1, input int z2, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start               <= 1'b1;
      req_x_sample_first  <= SAMPLE_BITS'(x1);
      req_x_sample_second <= SAMPLE_BITS'(x2);
      req_y_sample_first  <= SAMPLE_BITS'(y1);
      req_y_sample_second <= SAMPLE_BITS'(y2);
      req_z_first_sample  <= SAMPLE_BITS'(z1);
      req_z_second_sample <= SAMPLE_BITS'(z2);
      do @(posedge clock); while (busy);
   endtask

   // Stops sending and waits until every owed result word has come back. The
   // first edge lets the checker count the word that was just taken.
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // A second sample that mostly lands within reach of the tolerance, so that
   // most readings are valid points, and sometimes anywhere on the scale.
   function automatic int pair_sample(input int a, input int spread);
      int b;
      if ($urandom_range(99) < 80) begin
         b = a + int'($urandom_range(2 * spread + 4)) - spread - 2;
         if (b < 0) b = 0;
         if (b > 1023) b = 1023;
      end else begin
         b = $urandom_range(1023);
      end
      return b;
   endfunction

   // Programs one register setting, then sends random readings under one idle
   // pattern and drains the block before the next setting.
   task automatic run_phase(input int plate, input int tol, input int idle_pct,
                            input int count);
      int x1, y1, z1;
      program_registers(plate, tol);
      repeat (count) begin
         x1 = $urandom_range(1023);
         y1 = $urandom_range(1023);
         // Z1 of zero is the invalid-pressure case; give it a fair share.
         z1 = ($urandom_range(19) == 0) ? 0 : $urandom_range(1023);
         drive_word(x1, pair_sample(x1, tol), y1, pair_sample(y1, tol), z1,
                    ($urandom_range(3) == 0) ? pair_sample(z1, 8) : $urandom_range(1023),
                    idle_pct);
      end
      wait_idle();
   endtask

   initial begin
      reset               <= 1'b1;
      start               <= 1'b0;
      req_x_sample_first  <= '0;
      req_x_sample_second <= '0;
      req_y_sample_first  <= '0;
      req_y_sample_second <= '0;
      req_z_first_sample  <= '0;
      req_z_second_sample <= '0;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset setting: raw pressure mode, tolerance of four.
      drive_word(0, 0, 0, 0, 0, 0, 0);                  // Z1 of zero, invalid point
      drive_word(1023, 1023, 1023, 1023, 1023, 1023, 0); // everything at full scale
      drive_word(0, 4, 1023, 1019, 1, 1023, 0);         // pairs exactly at tolerance
      drive_word(511, 512, 200, 203, 1023, 1, 0);       // Z2 below Z1
      drive_word(10, 15, 300, 300, 500, 600, 0);        // X pair one past tolerance
      drive_word(700, 700, 500, 505, 500, 600, 0);      // Y pair one past tolerance
      drive_word(1023, 1019, 3, 7, 512, 256, 0);
      wait_idle();

      // Scaled mode with the largest plate resistance.
      program_registers(65535, 4);
      drive_word(1023, 1023, 1023, 1023, 1023, 1023, 0); // equal Z, zero pressure
      drive_word(0, 0, 512, 512, 1, 1023, 0);           // largest positive pressure
      drive_word(0, 1, 512, 512, 1023, 1, 0);           // large negative pressure
      drive_word(1023, 1023, 40, 41, 1023, 1, 0);       // X position zero, negative sign
      drive_word(100, 100, 100, 100, 0, 900, 0);        // Z1 of zero in scaled mode
      drive_word(0, 1023, 100, 100, 300, 900, 0);       // X pair far apart
      drive_word(100, 100, 1023, 0, 300, 900, 0);       // Y pair far apart
      drive_word(1, 2, 5, 6, 333, 334, 0);              // odd sums round down
      drive_word(0, 0, 0, 0, 1, 0, 0);                  // Z2 of zero below Z1
      wait_idle();

      // Smallest plate and zero tolerance: only equal pairs pass.
      program_registers(1, 0);
      drive_word(5, 5, 9, 9, 2, 1000, 0);
      drive_word(5, 6, 9, 9, 2, 1000, 0);
      wait_idle();

      // Random phases. Each pairs a register setting with a sender idle
      // pattern: none, idle in most cycles, idle in about a quarter.
      run_phase(0, 1023, 0, 320);
      run_phase(65535, 0, 77, 320);
      run_phase($urandom_range(65535), $urandom_range(16), 23, 320);
      run_phase(1, 4, 0, 320);
      run_phase($urandom_range(65535), 1023, 77, 320);
      run_phase($urandom_range(65535), $urandom_range(1023), 23, 320);

      // Give a stray late word the time to show up before the verdict.
      repeat (LATENCY + 6) @(posedge clock);
      if (failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
